>>> src/lwbc_pkg.sv
package lwbc_pkg;

  localparam int REQ_BITS  = 3;
  localparam int LAT_BITS  = 16;
  localparam int SLOT_BITS = 6;
  localparam int CFG_BITS  = 7;
  localparam int FLAG_BITS = 4;

  localparam logic [REQ_BITS-1:0] REQ_READ      = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_WRITE     = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_FLUSH     = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_FLUSH_ALL = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR     = 3'd4;

  localparam logic [CFG_BITS-1:0] LIMIT_RESET = 7'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FILL,
    ST_UPDATE,
    ST_EMIT,
    ST_FA_SCAN,
    ST_FA_PICK
  } state_t;

endpackage

>>> src/lwbc_tag_ram.sv
module lwbc_tag_ram #(
  parameter int DEPTH      = 16,
  parameter int BLOCK_BITS = 32,
  parameter int TIME_BITS  = 40
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [BLOCK_BITS-1:0]                  wr_block,
  input  logic [TIME_BITS-1:0]                   wr_age,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [BLOCK_BITS-1:0]                  rd_block,
  output logic [TIME_BITS-1:0]                   rd_age
);

  logic [BLOCK_BITS-1:0] mem_block [DEPTH];
  logic [TIME_BITS-1:0]  mem_age   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_block[wr_addr] <= wr_block;
      mem_age[wr_addr]   <= wr_age;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_block <= mem_block[rd_addr];
      rd_age   <= mem_age[rd_addr];
    end
  end

endmodule

>>> src/lru_write_back_block_cache.sv
// results: each request is answered after a scan of all slots, one slot per cycle; clear and
//   clean flush-all skip the scan and are answered straight away
// flush-all: one result per dirty entry written back, each after a full memory pass
// acceptance: a new transaction is taken the cycle after the last result of the previous one
//   is loaded into the output register
// reset: all slots invalid and clean, running time zero, cache_limit 16; no clearing pass
module lru_write_back_block_cache #(
  parameter int CACHE_SLOTS = 16,
  parameter int BLOCK_BITS  = 32,
  parameter int TIME_BITS   = 40
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  // configuration: cache_limit
  input  logic                                                 cfg_we,
  input  logic [lwbc_pkg::CFG_BITS-1:0]                        cfg_wdata,
  // request stream
  input  logic                                                 s_axis_tvalid,
  output logic                                                 s_axis_tready,
  // tdata: block_num, fetch_time, writeback_time (zero padded to bytes)
  input  logic [((BLOCK_BITS+2*lwbc_pkg::LAT_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic [lwbc_pkg::REQ_BITS-1:0]                        s_axis_tuser,
  // result stream
  output logic                                                 m_axis_tvalid,
  input  logic                                                 m_axis_tready,
  // tdata: slot, evicted_block, time_now (zero padded to bytes)
  output logic [((lwbc_pkg::SLOT_BITS+BLOCK_BITS+TIME_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser: hit, fetch, evicted, writeback
  output logic [lwbc_pkg::FLAG_BITS-1:0]                       m_axis_tuser,
  // tlast: last
  output logic                                                 m_axis_tlast
);

  import lwbc_pkg::*;

  localparam int IDX_W   = CACHE_SLOTS > 1 ? $clog2(CACHE_SLOTS) : 1;
  localparam int CNT_W   = $clog2(CACHE_SLOTS + 1);
  localparam int OUT_W   = ((SLOT_BITS + BLOCK_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - (SLOT_BITS + BLOCK_BITS + TIME_BITS);
  localparam logic [CFG_BITS-1:0] SLOTS_LIM = CFG_BITS'(CACHE_SLOTS);
  localparam logic [CNT_W-1:0]    SCAN_END  = CNT_W'(CACHE_SLOTS);

  // control state
  state_t                  state, state_next;
  logic [CACHE_SLOTS-1:0]  valid, valid_next;
  logic [CACHE_SLOTS-1:0]  dirty, dirty_next;
  logic [TIME_BITS-1:0]    run_time, run_time_next;
  logic [CFG_BITS-1:0]     cache_limit;

  // latched request
  logic [REQ_BITS-1:0]     req;
  logic [BLOCK_BITS-1:0]   blk;
  logic [LAT_BITS-1:0]     ft;
  logic [LAT_BITS-1:0]     wt;

  // scan pipeline: issue a memory read, evaluate the returned slot in the following cycle
  logic [CNT_W-1:0]        iss_cnt;
  logic                    chk_vld;
  logic [IDX_W-1:0]        chk_idx;

  // scan results
  logic                    found;
  logic [IDX_W-1:0]        f_idx;
  logic [CNT_W-1:0]        cnt;
  logic                    vic_found;
  logic [IDX_W-1:0]        vic_idx;
  logic [TIME_BITS-1:0]    vic_age;
  logic [BLOCK_BITS-1:0]   vic_block;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic                    pick_found;
  logic [IDX_W-1:0]        pick_idx;
  logic [BLOCK_BITS-1:0]   pick_block;

  // pending result fields
  logic                    res_hit;
  logic                    res_fetch;
  logic                    res_ev;
  logic                    res_wb;
  logic                    res_last;
  logic [IDX_W-1:0]        res_slot;
  logic [BLOCK_BITS-1:0]   res_eb;
  logic [IDX_W-1:0]        ins_idx;

  // memory interface
  logic                    mem_wr_en;
  logic                    mem_rd_en;
  logic [BLOCK_BITS-1:0]   rd_block;
  logic [TIME_BITS-1:0]    rd_age;

  // misc decode
  logic                    in_accept;
  logic                    out_free;
  logic                    out_load;
  logic                    is_write;
  logic                    scan_done;
  logic                    evict;
  logic                    fa_last;
  logic [CFG_BITS-1:0]     lim_eff;
  logic [CACHE_SLOTS-1:0]  pick_mask;
  logic [LAT_BITS-1:0]     adv_delta;
  logic [TIME_BITS:0]      adv_sum;
  logic [TIME_BITS-1:0]    adv_time;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign is_write  = (req == REQ_WRITE);
  assign scan_done = (iss_cnt == SCAN_END) && !chk_vld;
  assign mem_rd_en = (state == ST_SCAN || state == ST_FA_SCAN) && (iss_cnt != SCAN_END);

  // limit 0 behaves as 1, anything above the slot count as the slot count
  assign lim_eff = (cache_limit == '0) ? CFG_BITS'(1) :
                   (cache_limit > SLOTS_LIM) ? SLOTS_LIM : cache_limit;
  assign evict   = (CFG_BITS'(cnt) >= lim_eff) || !free_found;

  assign pick_mask = CACHE_SLOTS'(1) << pick_idx;
  assign fa_last   = ((valid & dirty & ~pick_mask) == '0);

  // saturating time advance; the fill step adds the fetch latency, all others write-back
  assign adv_delta = (state == ST_FILL) ? ft : wt;
  assign adv_sum   = {1'b0, run_time} + (TIME_BITS+1)'(adv_delta);
  assign adv_time  = adv_sum[TIME_BITS] ? '1 : adv_sum[TIME_BITS-1:0];

  lwbc_tag_ram #(
    .DEPTH      (CACHE_SLOTS),
    .BLOCK_BITS (BLOCK_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_tag_ram (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (ins_idx),
    .wr_block (blk),
    .wr_age   (run_time),
    .rd_en    (mem_rd_en),
    .rd_addr  (iss_cnt[IDX_W-1:0]),
    .rd_block (rd_block),
    .rd_age   (rd_age)
  );

  // next state, valid/dirty bits, running time, memory write, output load
  always_comb begin
    state_next    = state;
    valid_next    = valid;
    dirty_next    = dirty;
    run_time_next = run_time;
    mem_wr_en     = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser)
            REQ_READ, REQ_WRITE, REQ_FLUSH: begin
              state_next = ST_SCAN;
            end
            REQ_FLUSH_ALL: begin
              if ((valid & dirty) != '0) begin
                state_next = ST_FA_SCAN;
              end else begin
                // nothing dirty: drop everything, single empty result
                valid_next = '0;
                dirty_next = '0;
                state_next = ST_EMIT;
              end
            end
            REQ_CLEAR: begin
              valid_next = '0;
              dirty_next = '0;
              state_next = ST_EMIT;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (req == REQ_FLUSH) begin
          if (found) begin
            if (dirty[f_idx]) begin
              run_time_next = adv_time;
            end
            valid_next[f_idx] = 1'b0;
            dirty_next[f_idx] = 1'b0;
          end
          state_next = ST_EMIT;
        end else if (found) begin
          state_next = ST_UPDATE;
        end else begin
          // victim write-back happens before the fetch
          if (evict && dirty[vic_idx]) begin
            run_time_next = adv_time;
          end
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (!is_write) begin
          run_time_next = adv_time;
        end
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hit refreshes the age, miss installs block and age in the chosen slot
        mem_wr_en           = 1'b1;
        valid_next[ins_idx] = 1'b1;
        dirty_next[ins_idx] = found ? (dirty[ins_idx] | is_write) : is_write;
        state_next          = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = res_last ? ST_IDLE : ST_FA_SCAN;
        end
      end
      ST_FA_SCAN: begin
        if (scan_done) begin
          state_next = ST_FA_PICK;
        end
      end
      ST_FA_PICK: begin
        run_time_next        = adv_time;
        dirty_next[pick_idx] = 1'b0;
        if (fa_last) begin
          valid_next = '0;
          dirty_next = '0;
        end
        state_next = ST_EMIT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      dirty         <= '0;
      run_time      <= '0;
      cache_limit   <= LIMIT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      valid    <= valid_next;
      dirty    <= dirty_next;
      run_time <= run_time_next;
      if (cfg_we) begin
        cache_limit <= cfg_wdata;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // request latch, scan pipeline and result fields
  always_ff @(posedge clk) begin
    if (state == ST_IDLE || state == ST_EMIT) begin
      iss_cnt    <= '0;
      chk_vld    <= 1'b0;
      found      <= 1'b0;
      cnt        <= '0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
      pick_found <= 1'b0;
    end

    if (in_accept) begin
      req       <= s_axis_tuser;
      blk       <= s_axis_tdata[BLOCK_BITS-1:0];
      ft        <= s_axis_tdata[BLOCK_BITS +: LAT_BITS];
      wt        <= s_axis_tdata[BLOCK_BITS+LAT_BITS +: LAT_BITS];
      // empty result for clear and clean flush-all
      res_hit   <= 1'b0;
      res_fetch <= 1'b0;
      res_ev    <= 1'b0;
      res_wb    <= 1'b0;
      res_last  <= 1'b1;
      res_slot  <= '0;
      res_eb    <= '0;
    end

    if (state == ST_SCAN || state == ST_FA_SCAN) begin
      chk_vld <= mem_rd_en;
      chk_idx <= iss_cnt[IDX_W-1:0];
      if (mem_rd_en) begin
        iss_cnt <= iss_cnt + CNT_W'(1);
      end
    end

    if (state == ST_SCAN && chk_vld) begin
      if (valid[chk_idx]) begin
        cnt <= cnt + CNT_W'(1);
        if (!found && rd_block == blk) begin
          found <= 1'b1;
          f_idx <= chk_idx;
        end
        // least recent age wins, ties to the lower block number
        if (!vic_found || rd_age < vic_age ||
            (rd_age == vic_age && rd_block < vic_block)) begin
          vic_found <= 1'b1;
          vic_idx   <= chk_idx;
          vic_age   <= rd_age;
          vic_block <= rd_block;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
    end

    if (state == ST_FA_SCAN && chk_vld) begin
      if (valid[chk_idx] && dirty[chk_idx] && (!pick_found || rd_block < pick_block)) begin
        pick_found <= 1'b1;
        pick_idx   <= chk_idx;
        pick_block <= rd_block;
      end
    end

    if (state == ST_DECIDE) begin
      res_last  <= 1'b1;
      res_fetch <= 1'b0;
      res_hit   <= 1'b0;
      res_ev    <= 1'b0;
      res_wb    <= 1'b0;
      res_eb    <= '0;
      res_slot  <= '0;
      if (req == REQ_FLUSH) begin
        if (found) begin
          res_hit  <= 1'b1;
          res_ev   <= 1'b1;
          res_wb   <= dirty[f_idx];
          res_eb   <= blk;
          res_slot <= f_idx;
        end
      end else if (found) begin
        res_hit  <= 1'b1;
        res_slot <= f_idx;
        ins_idx  <= f_idx;
      end else if (evict) begin
        res_fetch <= !is_write;
        res_ev    <= 1'b1;
        res_wb    <= dirty[vic_idx];
        res_eb    <= vic_block;
        res_slot  <= vic_idx;
        ins_idx   <= vic_idx;
      end else begin
        res_fetch <= !is_write;
        res_slot  <= free_idx;
        ins_idx   <= free_idx;
      end
    end

    if (state == ST_FA_PICK) begin
      res_hit   <= 1'b0;
      res_fetch <= 1'b0;
      res_ev    <= 1'b1;
      res_wb    <= 1'b1;
      res_eb    <= pick_block;
      res_slot  <= pick_idx;
      res_last  <= fa_last;
    end

    if (out_load) begin
      m_axis_tdata <= {{OUT_PAD{1'b0}}, run_time, res_eb, SLOT_BITS'(res_slot)};
      m_axis_tuser <= {res_wb, res_ev, res_fetch, res_hit};
      m_axis_tlast <= res_last;
    end
  end

endmodule

>>> tb/sv/lru_cache_checker.sv
`timescale 1ns / 1ps

module lru_cache_checker #(
  parameter int CACHE_SLOTS = 16,
  parameter int BLOCK_BITS  = 32,
  parameter int TIME_BITS   = 40,
  parameter int IN_W        = ((BLOCK_BITS + 2 * lwbc_pkg::LAT_BITS + 7) / 8) * 8,
  parameter int OUT_W       = ((lwbc_pkg::SLOT_BITS + BLOCK_BITS + TIME_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lwbc_pkg::CFG_BITS-1:0]    cfg_wdata,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [IN_W-1:0]                  s_axis_tdata,
  input  logic [lwbc_pkg::REQ_BITS-1:0]    s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [OUT_W-1:0]                 m_axis_tdata,
  input  logic [lwbc_pkg::FLAG_BITS-1:0]   m_axis_tuser,
  input  logic                             m_axis_tlast,
  output int                               open_replies,
  output int                               errors
);

  import lwbc_pkg::*;

  localparam int FLAG_HIT   = 0;
  localparam int FLAG_FETCH = 1;
  localparam int FLAG_EVICT = 2;
  localparam int FLAG_WB    = 3;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_BITS-1:0]  slot;
    logic                  fetch;
    logic                  evicted;
    logic                  writeback;
    logic [BLOCK_BITS-1:0] victim_block;
    logic                  last;
    logic [TIME_BITS-1:0]  time_now;
  } cache_reply_t;

  // shadow copy of the tag store
  logic                  line_valid [CACHE_SLOTS];
  logic [BLOCK_BITS-1:0] line_block [CACHE_SLOTS];
  logic                  line_dirty [CACHE_SLOTS];
  logic [TIME_BITS-1:0]  line_stamp [CACHE_SLOTS];
  logic [TIME_BITS-1:0]  clock_now;
  logic [CFG_BITS-1:0]   limit_reg;

  cache_reply_t cache_replies [$];
  int           fail_count = 0;
  int           reply_no = 0;
  int           open_count = 0;

  logic [BLOCK_BITS-1:0] in_block;
  logic [LAT_BITS-1:0]   in_fetch_lat;
  logic [LAT_BITS-1:0]   in_wb_lat;

  assign in_block     = s_axis_tdata[BLOCK_BITS-1:0];
  assign in_fetch_lat = s_axis_tdata[BLOCK_BITS +: LAT_BITS];
  assign in_wb_lat    = s_axis_tdata[BLOCK_BITS+LAT_BITS +: LAT_BITS];
  assign errors       = fail_count;
  assign open_replies = open_count;

  function automatic logic [TIME_BITS-1:0] time_after(input logic [TIME_BITS-1:0] t,
                                                      input logic [LAT_BITS-1:0] d);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, t} + (TIME_BITS+1)'(d);
    return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic add_reply(input logic hit, input int slot, input logic fetch,
                           input logic evicted, input logic writeback,
                           input logic [BLOCK_BITS-1:0] victim_block, input logic last);
    cache_reply_t r;
    r.hit          = hit;
    r.slot         = slot[SLOT_BITS-1:0];
    r.fetch        = fetch;
    r.evicted      = evicted;
    r.writeback    = writeback;
    r.victim_block = victim_block;
    r.last         = last;
    r.time_now     = clock_now;
    cache_replies.push_back(r);
  endtask

  task automatic serve_access(input logic [BLOCK_BITS-1:0] blk, input logic is_write,
                              input logic [LAT_BITS-1:0] fetch_lat,
                              input logic [LAT_BITS-1:0] wb_lat);
    int hit_at, free_at, victim, count, lim, target;
    logic ev, wb;
    logic [BLOCK_BITS-1:0] gone;
    hit_at  = -1;
    free_at = -1;
    victim  = -1;
    count   = 0;
    ev      = 1'b0;
    wb      = 1'b0;
    gone    = '0;
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (hit_at < 0 && line_valid[i] && line_block[i] == blk) hit_at = i;
    if (hit_at >= 0) begin
      line_stamp[hit_at] = clock_now;
      if (is_write) line_dirty[hit_at] = 1'b1;
      add_reply(1'b1, hit_at, 1'b0, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    lim = int'(limit_reg);
    if (lim == 0) lim = 1;
    if (lim > CACHE_SLOTS) lim = CACHE_SLOTS;
    // oldest stamp loses, lower block number breaks a tie
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (line_valid[i]) begin
        count++;
        if (victim < 0 || line_stamp[i] < line_stamp[victim] ||
            (line_stamp[i] == line_stamp[victim] && line_block[i] < line_block[victim]))
          victim = i;
      end else if (free_at < 0) begin
        free_at = i;
      end
    end
    if (count >= lim || free_at < 0) begin
      target = victim;
      ev     = 1'b1;
      gone   = line_block[victim];
      if (line_dirty[victim]) begin
        wb        = 1'b1;
        clock_now = time_after(clock_now, wb_lat);
      end
      line_valid[victim] = 1'b0;
    end else begin
      target = free_at;
    end
    if (!is_write) clock_now = time_after(clock_now, fetch_lat);
    line_valid[target] = 1'b1;
    line_block[target] = blk;
    line_dirty[target] = is_write;
    line_stamp[target] = clock_now;
    add_reply(1'b0, target, !is_write, ev, wb, gone, 1'b1);
  endtask

  task automatic serve_flush_one(input logic [BLOCK_BITS-1:0] blk,
                                 input logic [LAT_BITS-1:0] wb_lat);
    int at;
    at = -1;
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (at < 0 && line_valid[i] && line_block[i] == blk) at = i;
    if (at < 0) begin
      add_reply(1'b0, 0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    if (line_dirty[at]) clock_now = time_after(clock_now, wb_lat);
    add_reply(1'b1, at, 1'b0, 1'b1, line_dirty[at], line_block[at], 1'b1);
    line_valid[at] = 1'b0;
    line_dirty[at] = 1'b0;
  endtask

  task automatic serve_flush_all(input logic [LAT_BITS-1:0] wb_lat);
    logic taken [CACHE_SLOTS];
    int order [$];
    int pick;
    for (int i = 0; i < CACHE_SLOTS; i++) taken[i] = 1'b0;
    // dirty entries go out in ascending block order
    do begin
      pick = -1;
      for (int i = 0; i < CACHE_SLOTS; i++)
        if (line_valid[i] && line_dirty[i] && !taken[i] &&
            (pick < 0 || line_block[i] < line_block[pick]))
          pick = i;
      if (pick >= 0) begin
        taken[pick] = 1'b1;
        order.push_back(pick);
      end
    end while (pick >= 0);
    if (order.size() == 0) begin
      add_reply(1'b0, 0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
    end else begin
      foreach (order[k]) begin
        clock_now = time_after(clock_now, wb_lat);
        add_reply(1'b0, order[k], 1'b0, 1'b1, 1'b1, line_block[order[k]],
                  k == order.size() - 1);
      end
    end
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", reply_no, name, got, want));
  endtask

  task automatic check_reply();
    cache_reply_t want;
    reply_no++;
    if (cache_replies.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no request outstanding", reply_no));
      return;
    end
    want = cache_replies.pop_front();
    check_field("hit", 64'(m_axis_tuser[FLAG_HIT]), 64'(want.hit));
    check_field("slot", 64'(m_axis_tdata[SLOT_BITS-1:0]), 64'(want.slot));
    check_field("fetch", 64'(m_axis_tuser[FLAG_FETCH]), 64'(want.fetch));
    check_field("evicted", 64'(m_axis_tuser[FLAG_EVICT]), 64'(want.evicted));
    check_field("writeback", 64'(m_axis_tuser[FLAG_WB]), 64'(want.writeback));
    check_field("evicted_block", 64'(m_axis_tdata[SLOT_BITS +: BLOCK_BITS]),
                64'(want.victim_block));
    check_field("last", 64'(m_axis_tlast), 64'(want.last));
    check_field("time_now", 64'(m_axis_tdata[SLOT_BITS+BLOCK_BITS +: TIME_BITS]),
                64'(want.time_now));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
      clock_now = '0;
      limit_reg = LIMIT_RESET;
    end else begin
      if (cfg_we) limit_reg = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) check_reply();
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          REQ_READ:      serve_access(in_block, 1'b0, in_fetch_lat, in_wb_lat);
          REQ_WRITE:     serve_access(in_block, 1'b1, in_fetch_lat, in_wb_lat);
          REQ_FLUSH:     serve_flush_one(in_block, in_wb_lat);
          REQ_FLUSH_ALL: serve_flush_all(in_wb_lat);
          REQ_CLEAR: begin
            for (int i = 0; i < CACHE_SLOTS; i++) begin
              line_valid[i] = 1'b0;
              line_dirty[i] = 1'b0;
            end
            add_reply(1'b0, 0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
          end
          default: ;
        endcase
      end
    end
    open_count <= cache_replies.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import lwbc_pkg::*;

  localparam int CACHE_SLOTS = 16;
  localparam int BLOCK_BITS  = 32;
  localparam int TIME_BITS   = 40;
  localparam int IN_W        = ((BLOCK_BITS + 2 * LAT_BITS + 7) / 8) * 8;
  localparam int OUT_W       = ((SLOT_BITS + BLOCK_BITS + TIME_BITS + 7) / 8) * 8;

  // request codes the block ignores
  localparam logic [REQ_BITS-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED_HI = 3'd7;

  // quiet margin once every predicted result has been taken and the block sits idle
  localparam int SETTLE_CYCLES = 3 * (CACHE_SLOTS + 6);
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 5000;
  localparam int PHASE_COUNT   = 9;
  localparam int PHASE_ITEMS   = 25;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_BITS-1:0]  cfg_wdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;   // block_num, fetch_time, writeback_time
  logic [REQ_BITS-1:0]  s_axis_tuser;   // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;   // slot, evicted_block, time_now, zero pad
  logic [FLAG_BITS-1:0] m_axis_tuser;   // hit, fetch, evicted, writeback
  logic                 m_axis_tlast;   // last

  int   open_replies;
  int   errors;
  int   burst_left = 0;
  int   quiet_cycles = 0;
  logic hold_wanted = 1'b0;

  lru_write_back_block_cache #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .BLOCK_BITS  (BLOCK_BITS),
    .TIME_BITS   (TIME_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // watches both channels, predicts every result and counts mismatches
  lru_cache_checker #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .BLOCK_BITS  (BLOCK_BITS),
    .TIME_BITS   (TIME_BITS)
  ) reply_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .open_replies  (open_replies),
    .errors        (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: too long without any transaction on either side means a hang
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: changing stall pattern, plus one long hold-off to back the block up
  initial begin : result_sink
    int   mode;
    int   mode_left;
    logic held;
    mode          = 0;
    mode_left     = 0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !held) begin
        // sender keeps offering while nothing drains, so the input stalls
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offers one request transaction and returns on the falling edge after it is taken;
  // bursts of back-to-back requests alternate with random gaps
  task automatic push_request(input logic [REQ_BITS-1:0] req,
                              input logic [BLOCK_BITS-1:0] blk,
                              input logic [LAT_BITS-1:0] fetch_lat,
                              input logic [LAT_BITS-1:0] wb_lat);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {wb_lat, fetch_lat, blk};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // stop offering, wait out every pending result and any request that gives none
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (open_replies != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_cache_limit(input logic [CFG_BITS-1:0] value);
    drain();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // cache_limit per phase: zero, past the slot count and the full 7-bit range included
  function automatic logic [CFG_BITS-1:0] phase_limit(input int p);
    case (p)
      0:       return 7'd0;
      1:       return 7'd2;
      2:       return 7'd127;
      3:       return 7'd5;
      4:       return 7'd16;
      5:       return 7'd64;
      6:       return 7'd1;
      7:       return 7'd3;
      default: return 7'd8;
    endcase
  endfunction

  // mostly zero or short latencies so stamps tie often, now and then full range
  function automatic logic [LAT_BITS-1:0] draw_latency();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return '0;
    if (r < 85) return LAT_BITS'($urandom_range(1, 40));
    return LAT_BITS'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [REQ_BITS-1:0] draw_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 44) return REQ_READ;
    if (r < 76) return REQ_WRITE;
    if (r < 88) return REQ_FLUSH;
    if (r < 92) return REQ_FLUSH_ALL;
    if (r < 95) return REQ_CLEAR;
    return REQ_BITS'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
  endfunction

  initial begin : stimulus
    int                   sent;
    int                   span;
    int                   eff;
    logic [BLOCK_BITS-1:0] pool_base;
    logic [BLOCK_BITS-1:0] blk;
    logic [REQ_BITS-1:0]   req;
    logic [CFG_BITS-1:0]   lim;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_READ;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed part, reset limit of 16
    push_request(REQ_FLUSH_ALL, 32'h0, 16'h0, 16'h0);            // nothing dirty
    push_request(REQ_FLUSH, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);     // absent block
    push_request(REQ_READ, 32'h0, 16'hFFFF, 16'h0);              // miss, fetch
    push_request(REQ_READ, 32'h0, 16'hFFFF, 16'hFFFF);           // hit
    push_request(REQ_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);  // write miss, no fetch
    push_request(REQ_WRITE, 32'h0, 16'h0, 16'h0);                // hit turns dirty
    push_request(REQ_READ, 32'hA5A5_A5A5, 16'h0, 16'h0);         // miss with zero fetch
    push_request(REQ_FLUSH, 32'h0, 16'h0, 16'h1234);             // dirty, written back
    push_request(REQ_FLUSH, 32'hA5A5_A5A5, 16'h0, 16'h5A5A);     // clean, just dropped
    push_request(REQ_WRITE, 32'h5, 16'h0, 16'h0);
    push_request(REQ_WRITE, 32'h3, 16'h0, 16'h0);
    push_request(REQ_READ, 32'h7, 16'h7, 16'h0);
    push_request(REQ_WRITE, 32'h7, 16'h0, 16'h0);
    push_request(REQ_UNUSED_LO, BLOCK_BITS'($urandom), LAT_BITS'($urandom),
                 LAT_BITS'($urandom));                            // ignored codes
    push_request(REQ_UNUSED_LO + 3'd1, BLOCK_BITS'($urandom), LAT_BITS'($urandom),
                 LAT_BITS'($urandom));
    push_request(REQ_UNUSED_HI, BLOCK_BITS'($urandom), LAT_BITS'($urandom),
                 LAT_BITS'($urandom));
    push_request(REQ_FLUSH_ALL, 32'h0, 16'h0, 16'h10);           // four write-backs in order
    push_request(REQ_READ, 32'h9, 16'h3, 16'h0);
    push_request(REQ_WRITE, 32'h2, 16'h0, 16'h0);
    push_request(REQ_CLEAR, 32'h2, 16'hFFFF, 16'hFFFF);          // dirty entry lost silently
    push_request(REQ_READ, 32'h2, 16'h1, 16'h0);                 // miss again after clear
    push_request(REQ_FLUSH_ALL, 32'h0, 16'h0, 16'h8);            // only clean entries left

    // random phases, cache state carries across limit changes so a lowered limit
    // meets a cache fuller than itself
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      lim = phase_limit(phase);
      set_cache_limit(lim);
      if (phase == 1) hold_wanted <= 1'b1;
      eff = (lim == 0) ? 1 : ((lim > CACHE_SLOTS) ? CACHE_SLOTS : int'(lim));
      span      = eff + $urandom_range(1, 6);
      pool_base = BLOCK_BITS'($urandom);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        req = draw_request();
        if ($urandom_range(0, 9) == 0)
          blk = BLOCK_BITS'($urandom);
        else
          blk = pool_base + BLOCK_BITS'($urandom_range(0, span));
        push_request(req, blk, draw_latency(), draw_latency());
        if (req <= REQ_CLEAR) sent++;
      end
    end

    drain();
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
src/lwbc_pkg.sv
src/lwbc_tag_ram.sv
src/lru_write_back_block_cache.sv
tb/sv/lru_cache_checker.sv
tb/sv/tb_top.sv
